/* hw/rtl/cau_pkg.sv */
// cau_pkg: shared codes and types for the complex arithmetic unit.
// No dependencies; used by the interfaces, cau_mac and complex_arithmetic_unit.
package cau_pkg;

    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_func FUNC_ADD = 3'd0;
    localparam t_func FUNC_SUB = 3'd1;
    localparam t_func FUNC_MUL = 3'd2;
    localparam t_func FUNC_DIV = 3'd3;
    localparam t_func FUNC_POW = 3'd4;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_OVF  = 2'd1;
    localparam t_status STAT_DIV0 = 2'd2;

    // request from the sequencer to the shift-add multiply unit
    typedef struct packed {
        logic start;
        logic clr;   // clear accumulator before this product
        logic sub;   // subtract the product instead of adding it
    } t_mac_req;

endpackage

/* hw/rtl/cau_if.sv */
// cau_if: valid/ready channels for operand items and result items.
// Depends on cau_pkg for the code types.
interface cau_in_if #(parameter int DATA_WIDTH = 32, parameter int EXP_BITS = 8);
    logic                         valid;
    logic                         ready;
    cau_pkg::t_func               func;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
    logic [EXP_BITS-1:0]          exponent;

    modport source (output valid, func, a_re, a_im, b_re, b_im, exponent, input ready);
    modport sink   (input valid, func, a_re, a_im, b_re, b_im, exponent, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    cau_pkg::t_status             status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

/* hw/rtl/cau_mac.sv */
// cau_mac: bit-serial signed multiply-accumulate, one multiplier bit a cycle.
// Depends on cau_pkg (t_mac_req).
module cau_mac #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cau_pkg::t_mac_req               i_req,
    input  logic signed [DATA_WIDTH-1:0]    i_x,
    input  logic signed [DATA_WIDTH-1:0]    i_y,
    output logic                            o_done,
    output logic signed [2*DATA_WIDTH+1:0]  o_acc
);
    localparam int AW = 2 * DATA_WIDTH + 2;
    localparam int CW = $clog2(DATA_WIDTH);

    logic signed [AW-1:0]   r_acc;
    logic signed [AW-1:0]   r_xs;
    logic [DATA_WIDTH-1:0]  r_y;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_sub;
    logic                   r_done;
    logic                   w_last;
    logic                   w_neg;

    assign w_last = (r_cnt == CW'(DATA_WIDTH - 1));
    // the sign bit of the multiplier weighs -2^(W-1)
    assign w_neg  = r_sub ^ w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_sub  <= i_req.sub;
                r_xs   <= {{(AW-DATA_WIDTH){i_x[DATA_WIDTH-1]}}, i_x};
                r_y    <= i_y;
                if (i_req.clr) begin
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                if (r_y[0]) begin
                    r_acc <= w_neg ? r_acc - r_xs : r_acc + r_xs;
                end
                r_xs  <= r_xs <<< 1;
                r_y   <= r_y >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

/* hw/rtl/cau_div.sv */
// cau_div: restoring divider, (|num| << FRAC_BITS) / den, one quotient bit a cycle,
// truncated toward zero and saturated to DATA_WIDTH. Depends on nothing else.
module cau_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [2*DATA_WIDTH+1:0]  i_num,
    input  logic [2*DATA_WIDTH+1:0]         i_den,
    output logic                            o_done,
    output logic signed [DATA_WIDTH-1:0]    o_q,
    output logic                            o_ovf
);
    localparam int AW = 2 * DATA_WIDTH + 2;
    localparam int NB = AW + FRAC_BITS;
    localparam int CW = $clog2(NB);
    localparam logic [DATA_WIDTH:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

    logic [NB-1:0]          r_dvd;
    logic [AW-1:0]          r_rem;
    logic [DATA_WIDTH:0]    r_q;
    logic                   r_big;
    logic                   r_neg;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [AW-1:0]          w_mag;
    logic [AW:0]            w_rem2;
    logic [AW:0]            w_diff;
    logic                   w_ge;
    logic [DATA_WIDTH:0]    w_lim;
    logic                   w_over;
    logic [DATA_WIDTH:0]    w_qmag;
    logic [DATA_WIDTH:0]    w_qval;

    assign w_mag  = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
    assign w_rem2 = {r_rem, r_dvd[NB-1]};
    assign w_diff = w_rem2 - {1'b0, i_den};
    assign w_ge   = (w_rem2 >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= {w_mag, {FRAC_BITS{1'b0}}};
                r_neg  <= i_num[AW-1];
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[AW-1:0] : w_rem2[AW-1:0];
                r_dvd <= r_dvd << 1;
                r_q   <= {r_q[DATA_WIDTH-1:0], w_ge};
                r_big <= r_big | r_q[DATA_WIDTH];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_lim  = r_neg ? LIM_NEG : LIM_POS;
    assign w_over = r_big | (r_q > w_lim);
    assign w_qmag = w_over ? w_lim : r_q;
    assign w_qval = r_neg ? -w_qmag : w_qmag;

    assign o_done = r_done;
    assign o_q    = w_qval[DATA_WIDTH-1:0];
    assign o_ovf  = w_over;
endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// complex_arithmetic_unit: fixed-point complex ALU (add, sub, mul, div, integer power).
// Depends on cau_pkg, cau_if, cau_mac and cau_div.
//
// Operands and results are signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS. One item in gives
// one result out; the block takes a new item only once the previous result has been
// taken. Add and subtract are computed straight from the input item. All products go
// through one shared bit-serial multiply-accumulate unit; a complex multiply takes
// four real products. Divide forms |b|^2 and the two numerator terms with six
// products, then runs the restoring divider twice, once for each part of the result.
// Power a^n takes n-1 complex multiplies; n=0 returns 1.0 (saturated max with overflow
// if 1.0 does not fit), n=1 returns a. Products are floored after the fraction shift,
// quotients truncate toward zero. Any saturated part sets status overflow (sticky
// across a power); a zero divisor gives 0+0i with status division-by-zero. Unused
// operation codes give 0+0i, ok.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int EXP_BITS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);
    localparam int W  = DATA_WIDTH;
    localparam int AW = 2 * DATA_WIDTH + 2;

    localparam logic [W-1:0] MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_NEG  = {1'b1, {(W-1){1'b0}}};
    localparam logic         ONE_FITS = (FRAC_BITS < W - 1);
    localparam logic [W-1:0] UNIT     = ONE_FITS ? (W'(1) << FRAC_BITS) : MAX_POS;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MGO   = 3'd1;
    localparam logic [2:0] S_MWAIT = 3'd2;
    localparam logic [2:0] S_DGO   = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // operand selects for the multiplier
    localparam logic [1:0] OPD_XR = 2'd0;
    localparam logic [1:0] OPD_XI = 2'd1;
    localparam logic [1:0] OPD_YR = 2'd2;
    localparam logic [1:0] OPD_YI = 2'd3;

    logic [2:0]             r_state;
    logic [2:0]             r_step;
    cau_pkg::t_func         r_func;
    logic [EXP_BITS-1:0]    r_pw;
    logic                   r_ovf;
    logic                   r_dz;
    logic                   r_dph;
    logic signed [W-1:0]    r_xr, r_xi, r_yr, r_yi;
    logic signed [W-1:0]    r_re, r_im;
    logic [AW-1:0]          r_den;
    logic signed [AW-1:0]   r_nr, r_ni;

    logic [1:0]             w_xsel, w_ysel;
    logic                   w_sub;
    cau_pkg::t_mac_req      w_mreq;
    logic signed [W-1:0]    w_mx, w_my;
    logic                   w_mac_done;
    logic signed [AW-1:0]   w_acc;
    logic [W:0]             w_sat;
    logic                   w_div_done;
    logic signed [W-1:0]    w_q;
    logic                   w_qovf;
    logic signed [AW-1:0]   w_num;

    logic                   w_is_sub;
    logic [W:0]             w_bre, w_bim, w_sre, w_sim;

    function automatic logic signed [W-1:0] pick(input logic [1:0] sel,
            input logic signed [W-1:0] xr, input logic signed [W-1:0] xi,
            input logic signed [W-1:0] yr, input logic signed [W-1:0] yi);
        logic signed [W-1:0] v;
        unique case (sel)
            OPD_XR:  v = xr;
            OPD_XI:  v = xi;
            OPD_YR:  v = yr;
            default: v = yi;
        endcase
        return v;
    endfunction

    // floor shift then clamp; MSB of the result is the overflow flag
    function automatic logic [W:0] sat_acc(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] sh;
        logic                 fits;
        sh   = acc >>> FRAC_BITS;
        fits = (&sh[AW-1:W-1]) | ~(|sh[AW-1:W-1]);
        if (fits) begin
            return {1'b0, sh[W-1:0]};
        end
        return {1'b1, sh[AW-1] ? MIN_NEG : MAX_POS};
    endfunction

    function automatic logic [W:0] sat_sum(input logic [W:0] s);
        if (s[W] == s[W-1]) begin
            return {1'b0, s[W-1:0]};
        end
        return {1'b1, s[W] ? MIN_NEG : MAX_POS};
    endfunction

    // --- add / subtract, straight from the input item ---
    assign w_is_sub = (i_in.func == cau_pkg::FUNC_SUB);
    assign w_bre = w_is_sub ? -{i_in.b_re[W-1], i_in.b_re} : {i_in.b_re[W-1], i_in.b_re};
    assign w_bim = w_is_sub ? -{i_in.b_im[W-1], i_in.b_im} : {i_in.b_im[W-1], i_in.b_im};
    assign w_sre = sat_sum({i_in.a_re[W-1], i_in.a_re} + w_bre);
    assign w_sim = sat_sum({i_in.a_im[W-1], i_in.a_im} + w_bim);

    // --- product program ---
    // complex multiply: re = xr*yr - xi*yi, im = xr*yi + xi*yr
    // divide: den = yr^2 + yi^2, nr = xr*yr + xi*yi, ni = xi*yr - xr*yi
    always_comb begin
        w_xsel = OPD_XR;
        w_ysel = OPD_YR;
        w_sub  = 1'b0;
        if (r_func == cau_pkg::FUNC_DIV) begin
            unique case (r_step)
                3'd0:    begin w_xsel = OPD_YR; w_ysel = OPD_YR; end
                3'd1:    begin w_xsel = OPD_YI; w_ysel = OPD_YI; end
                3'd2:    begin w_xsel = OPD_XR; w_ysel = OPD_YR; end
                3'd3:    begin w_xsel = OPD_XI; w_ysel = OPD_YI; end
                3'd4:    begin w_xsel = OPD_XI; w_ysel = OPD_YR; end
                3'd5:    begin w_xsel = OPD_XR; w_ysel = OPD_YI; w_sub = 1'b1; end
                default: begin w_xsel = OPD_XR; w_ysel = OPD_YR; end
            endcase
        end else begin
            unique case (r_step)
                3'd0:    begin w_xsel = OPD_XR; w_ysel = OPD_YR; end
                3'd1:    begin w_xsel = OPD_XI; w_ysel = OPD_YI; w_sub = 1'b1; end
                3'd2:    begin w_xsel = OPD_XR; w_ysel = OPD_YI; end
                3'd3:    begin w_xsel = OPD_XI; w_ysel = OPD_YR; end
                default: begin w_xsel = OPD_XR; w_ysel = OPD_YR; end
            endcase
        end
    end

    assign w_mx        = pick(w_xsel, r_xr, r_xi, r_yr, r_yi);
    assign w_my        = pick(w_ysel, r_xr, r_xi, r_yr, r_yi);
    assign w_mreq.start = (r_state == S_MGO);
    assign w_mreq.clr   = ~r_step[0];
    assign w_mreq.sub   = w_sub;

    cau_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .i_x     (w_mx),
        .i_y     (w_my),
        .o_done  (w_mac_done),
        .o_acc   (w_acc)
    );

    assign w_sat = sat_acc(w_acc);
    assign w_num = r_dph ? r_ni : r_nr;

    cau_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DGO),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_q     (w_q),
        .o_ovf   (w_qovf)
    );

    // --- sequencer ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_dph   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_func <= i_in.func;
                        r_dz   <= 1'b0;
                        r_step <= '0;
                        r_xr   <= i_in.a_re;
                        r_xi   <= i_in.a_im;
                        // power multiplies the running value by a itself
                        r_yr   <= (i_in.func == cau_pkg::FUNC_POW) ? i_in.a_re : i_in.b_re;
                        r_yi   <= (i_in.func == cau_pkg::FUNC_POW) ? i_in.a_im : i_in.b_im;
                        r_pw   <= i_in.exponent - EXP_BITS'(1);
                        unique case (i_in.func)
                            cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
                                r_re    <= w_sre[W-1:0];
                                r_im    <= w_sim[W-1:0];
                                r_ovf   <= w_sre[W] | w_sim[W];
                                r_state <= S_OUT;
                            end
                            cau_pkg::FUNC_MUL, cau_pkg::FUNC_DIV: begin
                                r_ovf   <= 1'b0;
                                r_state <= S_MGO;
                            end
                            cau_pkg::FUNC_POW: begin
                                if (i_in.exponent == '0) begin
                                    r_re    <= UNIT;
                                    r_im    <= '0;
                                    r_ovf   <= ~ONE_FITS;
                                    r_state <= S_OUT;
                                end else if (i_in.exponent == EXP_BITS'(1)) begin
                                    r_re    <= i_in.a_re;
                                    r_im    <= i_in.a_im;
                                    r_ovf   <= 1'b0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_ovf   <= 1'b0;
                                    r_state <= S_MGO;
                                end
                            end
                            default: begin
                                r_re    <= '0;
                                r_im    <= '0;
                                r_ovf   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MGO: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (w_mac_done) begin
                        if (r_func == cau_pkg::FUNC_DIV) begin
                            r_step <= r_step + 3'd1;
                            unique case (r_step)
                                3'd1: begin
                                    r_den <= w_acc;
                                    if (w_acc == '0) begin
                                        r_dz    <= 1'b1;
                                        r_re    <= '0;
                                        r_im    <= '0;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_state <= S_MGO;
                                    end
                                end
                                3'd3: begin
                                    r_nr    <= w_acc;
                                    r_state <= S_MGO;
                                end
                                3'd5: begin
                                    r_ni    <= w_acc;
                                    r_dph   <= 1'b0;
                                    r_state <= S_DGO;
                                end
                                default: r_state <= S_MGO;
                            endcase
                        end else begin
                            unique case (r_step)
                                3'd1: begin
                                    r_re    <= w_sat[W-1:0];
                                    r_ovf   <= r_ovf | w_sat[W];
                                    r_step  <= r_step + 3'd1;
                                    r_state <= S_MGO;
                                end
                                3'd3: begin
                                    r_im  <= w_sat[W-1:0];
                                    r_ovf <= r_ovf | w_sat[W];
                                    if (r_func == cau_pkg::FUNC_POW && r_pw > EXP_BITS'(1)) begin
                                        // next power: running value times a
                                        r_pw    <= r_pw - EXP_BITS'(1);
                                        r_xr    <= r_re;
                                        r_xi    <= w_sat[W-1:0];
                                        r_step  <= '0;
                                        r_state <= S_MGO;
                                    end else begin
                                        r_state <= S_OUT;
                                    end
                                end
                                default: begin
                                    r_step  <= r_step + 3'd1;
                                    r_state <= S_MGO;
                                end
                            endcase
                        end
                    end
                end
                S_DGO: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_ovf <= r_ovf | w_qovf;
                        if (!r_dph) begin
                            r_re    <= w_q;
                            r_dph   <= 1'b1;
                            r_state <= S_DGO;
                        end else begin
                            r_im    <= w_q;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = (r_state == S_OUT);
    assign o_out.res_re = r_re;
    assign o_out.res_im = r_im;
    assign o_out.status = r_dz  ? cau_pkg::STAT_DIV0 :
                          r_ovf ? cau_pkg::STAT_OVF  : cau_pkg::STAT_OK;

    // --- checks ---
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a result is pending");

    a_mac_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == S_MWAIT))
        else $error("multiplier finished outside its wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DWAIT))
        else $error("divider finished outside its wait state");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == cau_pkg::STAT_DIV0) |->
            (o_out.res_re == '0 && o_out.res_im == '0))
        else $error("zero divisor result is not zero");
endmodule
